// ===== rtl/image_mirror_rotate_from_orientation_top_defines.svh =====
// Assertion macros shared by the orientation pipeline.
// Both expect a signal clk in the scope where they are used; IMR_ASSERT also expects rst_n.
`ifndef IMAGE_MIRROR_ROTATE_FROM_ORIENTATION_TOP_DEFINES_SVH
`define IMAGE_MIRROR_ROTATE_FROM_ORIENTATION_TOP_DEFINES_SVH

// Checked only while out of reset
`define IMR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define IMR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/imr_pkg.sv =====
// Shared types, codes and compare helpers for the orientation pipeline.
// No dependencies; imported by every stage module and the top level.
package imr_pkg;

    localparam int COMPONENT_BITS_DEF = 16;
    // Widest magnitude the compare helpers see (cross product at 32-bit components)
    localparam int CMP_MAX_W = 64;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    typedef enum logic [1:0] {
        MIR_NONE  = 2'd0,
        MIR_KIND0 = 2'd1,
        MIR_KIND1 = 2'd2
    } mir_t;

    // Sign flags per component, bit 0 = x
    typedef struct packed {
        logic [2:0] row_pos;
        logic [2:0] row_neg;
        logic [2:0] col_pos;
        logic [2:0] col_neg;
    } sign_t;

    // Dominant axes picked in the second stage
    typedef struct packed {
        axis_t main_ax;
        axis_t row_max;
        axis_t col_max;
    } axes_t;

    // Largest: y wins ties against z, x only when strictly larger
    function automatic axis_t arg_max3(input logic [CMP_MAX_W-1:0] m0,
                                       input logic [CMP_MAX_W-1:0] m1,
                                       input logic [CMP_MAX_W-1:0] m2);
        axis_t k;
        if (m2 > m1)
        begin
            k = (m0 > m2) ? AXIS_X : AXIS_Z;
        end
        else
        begin
            k = (m0 > m1) ? AXIS_X : AXIS_Y;
        end
        return k;
    endfunction

    // Smallest: y wins ties against z, x only when strictly smaller
    function automatic axis_t arg_min3(input logic [CMP_MAX_W-1:0] m0,
                                       input logic [CMP_MAX_W-1:0] m1,
                                       input logic [CMP_MAX_W-1:0] m2);
        axis_t k;
        if (m2 < m1)
        begin
            k = (m0 < m2) ? AXIS_X : AXIS_Z;
        end
        else
        begin
            k = (m0 < m1) ? AXIS_X : AXIS_Y;
        end
        return k;
    endfunction

    // Select one of three flags by axis
    function automatic logic pick3(input logic [2:0] v, input axis_t a);
        logic r;
        unique case (a)
            AXIS_X:  r = v[0];
            AXIS_Y:  r = v[1];
            AXIS_Z:  r = v[2];
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/image_mirror_rotate_from_orientation_top.sv =====
// Orientation to rotation/mirror block: s_ channel takes nine direction
// components, m_ channel gives rotate_quarters in bits 1:0, mirror_mode in 3:2.
// Result is a three-stage pipeline: one transfer per cycle in, one out, while m_tready is high.
// Three pipeline registers (magnitudes and products, axis picks and cross
// differences, final decision) carry an item from its input transfer to
// m_tvalid in that order. A new item is taken every cycle while the output is
// taken every cycle; throughput is one item per cycle.
// Each stage holds its item while the stage behind it is full and stalled,
// so s_tready drops only when all three stages hold items and m_tready is
// low; bubbles in the pipe still accept new transfers during a stall.
// Reset (rst_n low, asynchronous) empties all stages; only the valid flags are reset, not the data registers.
// Uses imr_pkg, imr_front, imr_axes, imr_decide and the assertion macros.
`include "image_mirror_rotate_from_orientation_top_defines.svh"

module image_mirror_rotate_from_orientation_top #(
    parameter int COMPONENT_BITS = imr_pkg::COMPONENT_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // read_x, read_y, read_z, phase_x, phase_y, phase_z, slice_x, slice_y, slice_z
    input  logic [((9*COMPONENT_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // rotate_quarters, mirror_mode
    output logic [7:0]                                 m_tdata
);
    import imr_pkg::*;

    localparam int W = COMPONENT_BITS;

    logic                f_valid, f_ready;
    logic [2:0][W-1:0]   f_col_mag, f_row_mag, f_nrm_mag;
    logic [2:0][2*W-1:0] f_prod_p, f_prod_q;
    sign_t               f_signs;

    logic                a_valid, a_ready;
    axes_t               a_axes;
    sign_t               a_signs;
    logic [W-1:0]        a_row_spread, a_col_spread;
    logic [2:0][2*W-1:0] a_cross_mag;
    logic [2:0]          a_cross_pos;

    rot_t                rot;
    mir_t                mir;

    imr_front #(.COMPONENT_BITS(COMPONENT_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .comps     (s_tdata[9*W-1:0]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .col_mag   (f_col_mag),
        .row_mag   (f_row_mag),
        .nrm_mag   (f_nrm_mag),
        .prod_p    (f_prod_p),
        .prod_q    (f_prod_q),
        .signs     (f_signs)
    );

    imr_axes #(.COMPONENT_BITS(COMPONENT_BITS)) u_axes (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (f_valid),
        .in_ready   (f_ready),
        .col_mag    (f_col_mag),
        .row_mag    (f_row_mag),
        .nrm_mag    (f_nrm_mag),
        .prod_p     (f_prod_p),
        .prod_q     (f_prod_q),
        .signs_in   (f_signs),
        .out_valid  (a_valid),
        .out_ready  (a_ready),
        .axes       (a_axes),
        .signs      (a_signs),
        .row_spread (a_row_spread),
        .col_spread (a_col_spread),
        .cross_mag  (a_cross_mag),
        .cross_pos  (a_cross_pos)
    );

    imr_decide #(.COMPONENT_BITS(COMPONENT_BITS)) u_decide (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (a_valid),
        .in_ready        (a_ready),
        .axes            (a_axes),
        .signs           (a_signs),
        .row_spread      (a_row_spread),
        .col_spread      (a_col_spread),
        .cross_mag       (a_cross_mag),
        .cross_pos       (a_cross_pos),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .rotate_quarters (rot),
        .mirror_mode     (mir)
    );

    assign m_tdata = {4'b0000, mir, rot};

    `IMR_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !m_tvalid, "output valid during reset")
    `IMR_ASSERT(a_mir_code, m_tvalid |-> (mir == MIR_NONE || mir == MIR_KIND0 || mir == MIR_KIND1), "mirror code out of range")
    `IMR_ASSERT(a_half_turn_plain, (m_tvalid && rot == ROT_180) |-> (mir == MIR_NONE), "half turn combined with mirror")
    `IMR_ASSERT(a_quarter_mirror, (m_tvalid && (rot == ROT_90 || rot == ROT_270)) |-> (mir != MIR_KIND0), "quarter turn with mirror kind 0")
    `IMR_ASSERT(a_empty_accepts, !m_tvalid |-> s_tready, "input stalled with empty output")

endmodule

// ===== rtl/imr_front.sv =====
// First stage: magnitudes, sign flags and the six cross-product terms.
// Depends on imr_pkg.
module imr_front #(
    parameter int COMPONENT_BITS = imr_pkg::COMPONENT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [9*COMPONENT_BITS-1:0]     comps,      // read xyz, phase xyz, slice xyz
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0][COMPONENT_BITS-1:0]  col_mag,
    output logic [2:0][COMPONENT_BITS-1:0]  row_mag,
    output logic [2:0][COMPONENT_BITS-1:0]  nrm_mag,
    output logic [2:0][2*COMPONENT_BITS-1:0] prod_p,
    output logic [2:0][2*COMPONENT_BITS-1:0] prod_q,
    output imr_pkg::sign_t                  signs
);
    import imr_pkg::*;

    localparam int W = COMPONENT_BITS;

    logic signed [W-1:0]   col [3];
    logic signed [W-1:0]   row [3];
    logic signed [W-1:0]   nrm [3];
    logic                  valid_reg;
    logic                  load;
    logic [2:0][W-1:0]     col_mag_reg, row_mag_reg, nrm_mag_reg;
    logic [2:0][W-1:0]     col_mag_next, row_mag_next, nrm_mag_next;
    logic [2:0][2*W-1:0]   prod_p_reg, prod_q_reg, prod_p_next, prod_q_next;
    sign_t                 signs_reg, signs_next;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            col[i] = comps[i*W +: W];
            row[i] = comps[(3+i)*W +: W];
            nrm[i] = comps[(6+i)*W +: W];
            // Magnitude of the most negative value wraps to its exact unsigned value
            col_mag_next[i] = col[i][W-1] ? (~col[i] + 1'b1) : col[i];
            row_mag_next[i] = row[i][W-1] ? (~row[i] + 1'b1) : row[i];
            nrm_mag_next[i] = nrm[i][W-1] ? (~nrm[i] + 1'b1) : nrm[i];
            signs_next.row_pos[i] = !row[i][W-1] && (row[i] != '0);
            signs_next.row_neg[i] = row[i][W-1];
            signs_next.col_pos[i] = !col[i][W-1] && (col[i] != '0);
            signs_next.col_neg[i] = col[i][W-1];
        end
        prod_p_next[0] = (2*W)'(row[1]) * (2*W)'(col[2]);
        prod_q_next[0] = (2*W)'(row[2]) * (2*W)'(col[1]);
        prod_p_next[1] = (2*W)'(row[2]) * (2*W)'(col[0]);
        prod_q_next[1] = (2*W)'(row[0]) * (2*W)'(col[2]);
        prod_p_next[2] = (2*W)'(row[0]) * (2*W)'(col[1]);
        prod_q_next[2] = (2*W)'(row[1]) * (2*W)'(col[0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            col_mag_reg <= col_mag_next;
            row_mag_reg <= row_mag_next;
            nrm_mag_reg <= nrm_mag_next;
            prod_p_reg  <= prod_p_next;
            prod_q_reg  <= prod_q_next;
            signs_reg   <= signs_next;
        end
    end

    assign out_valid = valid_reg;
    assign col_mag   = col_mag_reg;
    assign row_mag   = row_mag_reg;
    assign nrm_mag   = nrm_mag_reg;
    assign prod_p    = prod_p_reg;
    assign prod_q    = prod_q_reg;
    assign signs     = signs_reg;

endmodule

// ===== rtl/imr_axes.sv =====
// Second stage: dominant axes, row and column spreads, cross-product
// differences as sign and magnitude. Depends on imr_pkg.
module imr_axes #(
    parameter int COMPONENT_BITS = imr_pkg::COMPONENT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [2:0][COMPONENT_BITS-1:0]   col_mag,
    input  logic [2:0][COMPONENT_BITS-1:0]   row_mag,
    input  logic [2:0][COMPONENT_BITS-1:0]   nrm_mag,
    input  logic [2:0][2*COMPONENT_BITS-1:0] prod_p,
    input  logic [2:0][2*COMPONENT_BITS-1:0] prod_q,
    input  imr_pkg::sign_t                   signs_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output imr_pkg::axes_t                   axes,
    output imr_pkg::sign_t                   signs,
    output logic [COMPONENT_BITS-1:0]        row_spread,
    output logic [COMPONENT_BITS-1:0]        col_spread,
    output logic [2:0][2*COMPONENT_BITS-1:0] cross_mag,
    output logic [2:0]                       cross_pos
);
    import imr_pkg::*;

    localparam int W = COMPONENT_BITS;

    logic                  valid_reg;
    logic                  load;
    axis_t                 row_min, col_min;
    logic [W-1:0]          rd12, rd20, rd01, cd12, cd20, cd01;
    logic [2*W:0]          diff [3];
    axes_t                 axes_reg, axes_next;
    sign_t                 signs_reg;
    logic [W-1:0]          row_spread_reg, row_spread_next;
    logic [W-1:0]          col_spread_reg, col_spread_next;
    logic [2:0][2*W-1:0]   cross_mag_reg, cross_mag_next;
    logic [2:0]            cross_pos_reg, cross_pos_next;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    function automatic logic [W-1:0] absdiff(input logic [W-1:0] a, input logic [W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    always_comb
    begin
        axes_next.main_ax = arg_max3(CMP_MAX_W'(nrm_mag[0]), CMP_MAX_W'(nrm_mag[1]),
                                     CMP_MAX_W'(nrm_mag[2]));
        axes_next.row_max = arg_max3(CMP_MAX_W'(row_mag[0]), CMP_MAX_W'(row_mag[1]),
                                     CMP_MAX_W'(row_mag[2]));
        axes_next.col_max = arg_max3(CMP_MAX_W'(col_mag[0]), CMP_MAX_W'(col_mag[1]),
                                     CMP_MAX_W'(col_mag[2]));
        row_min = arg_min3(CMP_MAX_W'(row_mag[0]), CMP_MAX_W'(row_mag[1]),
                           CMP_MAX_W'(row_mag[2]));
        col_min = arg_min3(CMP_MAX_W'(col_mag[0]), CMP_MAX_W'(col_mag[1]),
                           CMP_MAX_W'(col_mag[2]));

        // All pairwise spreads in parallel, then pick the pair opposite the minimum
        rd12 = absdiff(row_mag[1], row_mag[2]);
        rd20 = absdiff(row_mag[2], row_mag[0]);
        rd01 = absdiff(row_mag[0], row_mag[1]);
        cd12 = absdiff(col_mag[1], col_mag[2]);
        cd20 = absdiff(col_mag[2], col_mag[0]);
        cd01 = absdiff(col_mag[0], col_mag[1]);

        unique case (row_min)
            AXIS_X:  row_spread_next = rd12;
            AXIS_Y:  row_spread_next = rd20;
            AXIS_Z:  row_spread_next = rd01;
            default: row_spread_next = '0;
        endcase
        unique case (col_min)
            AXIS_X:  col_spread_next = cd12;
            AXIS_Y:  col_spread_next = cd20;
            AXIS_Z:  col_spread_next = cd01;
            default: col_spread_next = '0;
        endcase

        for (int i = 0; i < 3; i++)
        begin
            diff[i] = {prod_p[i][2*W-1], prod_p[i]} - {prod_q[i][2*W-1], prod_q[i]};
            // A zero difference counts as not positive
            cross_pos_next[i] = !diff[i][2*W] && (diff[i] != '0);
            cross_mag_next[i] = diff[i][2*W] ? (2*W)'(~diff[i] + 1'b1) : diff[i][2*W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            axes_reg       <= axes_next;
            signs_reg      <= signs_in;
            row_spread_reg <= row_spread_next;
            col_spread_reg <= col_spread_next;
            cross_mag_reg  <= cross_mag_next;
            cross_pos_reg  <= cross_pos_next;
        end
    end

    assign out_valid  = valid_reg;
    assign axes       = axes_reg;
    assign signs      = signs_reg;
    assign row_spread = row_spread_reg;
    assign col_spread = col_spread_reg;
    assign cross_mag  = cross_mag_reg;
    assign cross_pos  = cross_pos_reg;

endmodule

// ===== rtl/imr_decide.sv =====
// Third stage: row/column orientation, cross-product sign and the final
// rotation and mirror codes, held in the output register. Depends on imr_pkg.
module imr_decide #(
    parameter int COMPONENT_BITS = imr_pkg::COMPONENT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  imr_pkg::axes_t                   axes,
    input  imr_pkg::sign_t                   signs,
    input  logic [COMPONENT_BITS-1:0]        row_spread,
    input  logic [COMPONENT_BITS-1:0]        col_spread,
    input  logic [2:0][2*COMPONENT_BITS-1:0] cross_mag,
    input  logic [2:0]                       cross_pos,
    output logic                             out_valid,
    input  logic                             out_ready,
    output imr_pkg::rot_t                    rotate_quarters,
    output imr_pkg::mir_t                    mirror_mode
);
    import imr_pkg::*;

    logic       valid_reg;
    logic       load;
    rot_t       rot_reg, rot_next;
    mir_t       mir_reg, mir_next;
    axis_t      excl_ax, row_ax, last_ax, want_ax, cross_ax;
    logic [2:0] flag;
    logic       have_last;
    logic       row_first;
    logic       vr_pos, vr_neg, vc_pos, vc_neg;
    logic       orow, ocol;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        row_first = row_spread > col_spread;
        // The axis the deciding vector takes is struck from the other vector's choices
        excl_ax   = row_first ? axes.row_max : axes.col_max;

        flag[0] = (axes.main_ax != AXIS_X) && (excl_ax != AXIS_X);
        flag[1] = (axes.main_ax != AXIS_Y) && (excl_ax != AXIS_Y);
        flag[2] = (axes.main_ax != AXIS_Z) && (excl_ax != AXIS_Z);

        // Last remaining axis wins
        have_last = 1'b1;
        priority if (flag[2])
        begin
            last_ax = AXIS_Z;
        end
        else if (flag[1])
        begin
            last_ax = AXIS_Y;
        end
        else if (flag[0])
        begin
            last_ax = AXIS_X;
        end
        else
        begin
            last_ax   = AXIS_X;
            have_last = 1'b0;
        end

        if (row_first)
        begin
            row_ax = axes.row_max;
            vr_pos = pick3(signs.row_pos, axes.row_max);
            vr_neg = pick3(signs.row_neg, axes.row_max);
            vc_pos = have_last && pick3(signs.col_pos, last_ax);
            vc_neg = have_last && pick3(signs.col_neg, last_ax);
        end
        else
        begin
            row_ax = last_ax;
            vr_pos = have_last && pick3(signs.row_pos, last_ax);
            vr_neg = have_last && pick3(signs.row_neg, last_ax);
            vc_pos = pick3(signs.col_pos, axes.col_max);
            vc_neg = pick3(signs.col_neg, axes.col_max);
        end

        want_ax = (axes.main_ax == AXIS_X) ? AXIS_Y : AXIS_X;

        if (axes.main_ax == AXIS_Z)
        begin
            orow = vr_pos;
            ocol = vc_pos;
        end
        else if (row_ax == want_ax)
        begin
            orow = vr_pos;
            ocol = vc_neg;
        end
        else
        begin
            orow = vr_neg;
            ocol = vc_pos;
        end

        cross_ax = arg_max3(CMP_MAX_W'(cross_mag[0]), CMP_MAX_W'(cross_mag[1]),
                            CMP_MAX_W'(cross_mag[2]));

        rot_next = ROT_0;
        mir_next = MIR_NONE;
        if (row_ax == want_ax)
        begin
            if (orow && !ocol)
            begin
                mir_next = MIR_KIND1;
            end
            if (!orow && ocol)
            begin
                mir_next = MIR_KIND0;
            end
            if (!orow && !ocol)
            begin
                rot_next = ROT_180;
            end
        end
        else
        begin
            // Both flips only matter to the row sign; the mirror test compares the two
            rot_next = ((orow ^ (axes.main_ax == AXIS_X) ^ pick3(cross_pos, cross_ax)))
                       ? ROT_90 : ROT_270;
            if (orow == ocol)
            begin
                mir_next = MIR_KIND1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rot_reg <= rot_next;
            mir_reg <= mir_next;
        end
    end

    assign out_valid       = valid_reg;
    assign rotate_quarters = rot_reg;
    assign mirror_mode     = mir_reg;

endmodule

// ===== tb/tb_image_mirror_rotate_from_orientation_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for image_mirror_rotate_from_orientation_top: drives direction triples
// on the s_ stream and checks each rotation/mirror result against an in-bench predictor.
// Depends on imr_pkg and the top-level RTL only.
module tb_image_mirror_rotate_from_orientation_top;
    import imr_pkg::*;

    localparam int CB = 16;
    localparam int DW = ((9 * CB + 7) / 8) * 8;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int MAX_PRINTS = 40;

    typedef struct {
        logic [DW-1:0] item;
        rot_t          rot;
        mir_t          mir;
    } orient_result_t;

    class orient_scoreboard;
        orient_result_t pending_q[$];
        int             errors;

        function new();
            errors = 0;
        endfunction

        function int count();
            return pending_q.size();
        endfunction

        // y wins ties against z, x only when strictly larger
        function axis_t largest_axis(longint m0, longint m1, longint m2);
            axis_t  best;
            longint best_m;
            best = AXIS_Y;
            best_m = m1;
            if (m2 > best_m)
            begin
                best = AXIS_Z;
                best_m = m2;
            end
            if (m0 > best_m)
                best = AXIS_X;
            return best;
        endfunction

        function axis_t smallest_axis(longint m0, longint m1, longint m2);
            axis_t  best;
            longint best_m;
            best = AXIS_Y;
            best_m = m1;
            if (m2 < best_m)
            begin
                best = AXIS_Z;
                best_m = m2;
            end
            if (m0 < best_m)
                best = AXIS_X;
            return best;
        endfunction

        // spread of the two axes other than lo
        function longint axis_spread(longint m0, longint m1, longint m2, axis_t lo);
            longint m[3];
            longint a;
            longint b;
            m[0] = m0;
            m[1] = m1;
            m[2] = m2;
            a = m[(int'(lo) + 1) % 3];
            b = m[(int'(lo) + 2) % 3];
            return (a > b) ? a - b : b - a;
        endfunction

        function void predict_orientation(input logic [DW-1:0] d, output rot_t rot,
                                          output mir_t mir);
            longint col[3], row[3], nrm[3];
            longint cm[3], rm[3], nm[3], xm[3];
            bit     xp[3], rflag[3], cflag[3];
            axis_t  main_ax, rmax, rmin, cmax, cmin, row_ax, want, k;
            longint vrow, vcol, p, q;
            bit     orow, ocol;
            for (int i = 0; i < 3; i++)
            begin
                col[i] = longint'($signed(d[CB*i +: CB]));
                row[i] = longint'($signed(d[CB*(3+i) +: CB]));
                nrm[i] = longint'($signed(d[CB*(6+i) +: CB]));
                cm[i] = (col[i] < 0) ? -col[i] : col[i];
                rm[i] = (row[i] < 0) ? -row[i] : row[i];
                nm[i] = (nrm[i] < 0) ? -nrm[i] : nrm[i];
            end
            rot = ROT_0;
            mir = MIR_NONE;
            vrow = 0;
            vcol = 0;
            row_ax = AXIS_X;
            main_ax = largest_axis(nm[0], nm[1], nm[2]);
            rmax = largest_axis(rm[0], rm[1], rm[2]);
            rmin = smallest_axis(rm[0], rm[1], rm[2]);
            cmax = largest_axis(cm[0], cm[1], cm[2]);
            cmin = smallest_axis(cm[0], cm[1], cm[2]);
            for (int i = 0; i < 3; i++)
            begin
                rflag[i] = (i != int'(main_ax));
                cflag[i] = (i != int'(main_ax));
            end
            // the vector with the wider spread claims its axis first
            if (axis_spread(rm[0], rm[1], rm[2], rmin) > axis_spread(cm[0], cm[1], cm[2], cmin))
            begin
                cflag[rmax] = 1'b0;
                vrow = row[rmax];
                row_ax = rmax;
                for (int i = 0; i < 3; i++)
                    if (cflag[i])
                        vcol = col[i];
            end
            else
            begin
                rflag[cmax] = 1'b0;
                vcol = col[cmax];
                for (int i = 0; i < 3; i++)
                    if (rflag[i])
                    begin
                        vrow = row[i];
                        row_ax = axis_t'(i);
                    end
            end
            want = (main_ax == AXIS_X) ? AXIS_Y : AXIS_X;
            if (main_ax == AXIS_Z)
            begin
                orow = vrow > 0;
                ocol = vcol > 0;
            end
            else if (row_ax == want)
            begin
                orow = vrow > 0;
                ocol = vcol < 0;
            end
            else
            begin
                orow = vrow < 0;
                ocol = vcol > 0;
            end
            if (row_ax == want)
            begin
                if (orow && !ocol)
                    mir = MIR_KIND1;
                if (!orow && ocol)
                    mir = MIR_KIND0;
                if (!orow && !ocol)
                    rot = ROT_180;
            end
            else
            begin
                if (main_ax == AXIS_X)
                begin
                    orow = !orow;
                    ocol = !ocol;
                end
                // exact phase x read cross product, sign and magnitude per component
                for (int i = 0; i < 3; i++)
                begin
                    p = row[(i + 1) % 3] * col[(i + 2) % 3];
                    q = row[(i + 2) % 3] * col[(i + 1) % 3];
                    xp[i] = p > q;
                    xm[i] = (p > q) ? p - q : q - p;
                end
                k = largest_axis(xm[0], xm[1], xm[2]);
                if (xp[k])
                begin
                    orow = !orow;
                    ocol = !ocol;
                end
                rot = orow ? ROT_90 : ROT_270;
                if (orow == ocol)
                    mir = MIR_KIND1;
            end
        endfunction

        task report_mismatch(string what);
            if (errors < MAX_PRINTS)
                $display("%0t ERROR: %s", $realtime, what);
            errors++;
        endtask

        function void note_input(logic [DW-1:0] d);
            orient_result_t e;
            e.item = d;
            predict_orientation(d, e.rot, e.mir);
            pending_q.push_back(e);
        endfunction

        task check_result(logic [7:0] t);
            orient_result_t e;
            if (pending_q.size() == 0)
                report_mismatch($sformatf("result %h with no item pending", t));
            else
            begin
                e = pending_q.pop_front();
                if (t[1:0] != e.rot)
                    report_mismatch($sformatf("rotate_quarters %0d, want %0d, item %h",
                                              t[1:0], e.rot, e.item));
                if (t[3:2] != e.mir)
                    report_mismatch($sformatf("mirror_mode %0d, want %0d, item %h",
                                              t[3:2], e.mir, e.item));
            end
        endtask
    endclass

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [DW-1:0] s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [7:0]    m_tdata;

    orient_scoreboard sb = new();

    bit rx_stall_on = 1'b1;
    bit rx_hold_req = 1'b0;
    bit rx_holding  = 1'b0;

    image_mirror_rotate_from_orientation_top #(
        .COMPONENT_BITS(CB)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // note inputs and check results on the same edge the transfer happens
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_image_mirror_rotate_from_orientation_top NOT OK");
        $finish;
    end

    // result side: random stall bursts, one long hold on request
    initial
    begin
        m_tready = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                m_tready <= 1'b0;
                rx_holding = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
                rx_holding = 1'b0;
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else if (rx_stall_on && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    task automatic send_item(input logic [DW-1:0] d);
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic tx_idle(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // stop offering and hold until every pending result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (sb.count() != 0);
        @(posedge clk);
    endtask

    task automatic send_vectors(input int rx, input int ry, input int rz,
                                input int px, input int py, input int pz,
                                input int sx, input int sy, input int sz);
        logic [DW-1:0] d;
        d = '0;
        d[CB*0 +: CB] = CB'(rx);
        d[CB*1 +: CB] = CB'(ry);
        d[CB*2 +: CB] = CB'(rz);
        d[CB*3 +: CB] = CB'(px);
        d[CB*4 +: CB] = CB'(py);
        d[CB*5 +: CB] = CB'(pz);
        d[CB*6 +: CB] = CB'(sx);
        d[CB*7 +: CB] = CB'(sy);
        d[CB*8 +: CB] = CB'(sz);
        send_item(d);
    endtask

    function automatic int signed_pick(input int lo, input int hi);
        int v;
        v = $urandom_range(lo, hi);
        return ($urandom_range(0, 1) != 0) ? -v : v;
    endfunction

    function automatic logic [DW-1:0] random_orientation();
        logic [DW-1:0] d;
        int            kind;
        int            ax[3];
        int            pool[4];
        int            corner[6];
        int            v;
        d = '0;
        kind = $urandom_range(0, 99);
        corner = '{-32768, -32767, -1, 0, 1, 32767};
        // distinct dominant axes for read, phase and slice
        ax[2] = $urandom_range(0, 2);
        ax[0] = (ax[2] + 1 + $urandom_range(0, 1)) % 3;
        ax[1] = 3 - ax[2] - ax[0];
        pool[0] = 0;
        pool[1] = $urandom_range(1, 32767);
        pool[2] = ($urandom_range(0, 3) == 0) ? pool[1] : $urandom_range(1, 32767);
        pool[3] = 32768;
        for (int i = 0; i < 9; i++)
        begin
            if (kind < 40)
            begin
                if (i % 3 == ax[i / 3])
                    v = signed_pick(16000, 32767);
                else
                    v = signed_pick(0, 9000);
            end
            else if (kind < 60)
                v = $urandom_range(0, 65535);
            else if (kind < 85)
                v = ($urandom_range(0, 1) != 0) ? -pool[$urandom_range(0, 3)]
                                                 : pool[$urandom_range(0, 2)];
            else
                v = corner[$urandom_range(0, 5)];
            d[CB*i +: CB] = CB'(v);
        end
        return d;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, axis-aligned orientations and tie cases
        send_vectors(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_vectors(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        send_vectors(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        send_vectors(-1, -1, -1, -1, -1, -1, -1, -1, -1);
        send_vectors(1, 1, 1, 1, 1, 1, 1, 1, 1);
        send_vectors(32767, 0, 0, 0, 32767, 0, 0, 0, 32767);
        send_vectors(-32767, 0, 0, 0, 32767, 0, 0, 0, 32767);
        send_vectors(32767, 0, 0, 0, -32767, 0, 0, 0, 32767);
        send_vectors(-32767, 0, 0, 0, -32767, 0, 0, 0, -32767);
        send_vectors(0, 32767, 0, 32767, 0, 0, 0, 0, 32767);
        send_vectors(0, 32767, 0, -32767, 0, 0, 0, 0, -32767);
        send_vectors(0, 32767, 0, 0, 0, 32767, 32767, 0, 0);
        send_vectors(0, 0, 32767, 0, 32767, 0, 32767, 0, 0);
        send_vectors(0, 0, -32767, 0, -32767, 0, -32768, 0, 0);
        send_vectors(32767, 0, 0, 0, 0, 32767, 0, 32767, 0);
        send_vectors(0, 0, 32767, 32767, 0, 0, 0, -32767, 0);
        send_vectors(5, 5, 5, 5, 5, 5, 1000, 1000, 1000);
        send_vectors(300, -300, 0, 0, 300, -300, 2000, 0, -2000);
        send_vectors(7, 0, 0, 0, 7, 0, -32768, 32767, 32767);
        send_vectors(0, 0, 0, 0, 0, 100, 0, 0, 100);
        send_vectors(23170, 23170, 0, -23170, 23170, 0, 0, 0, 32767);
        send_vectors(100, -32768, 7, 32767, -1, 1, -1, 1, -32768);
        send_vectors(21845, -21846, 21845, -21846, 21845, -21846, 21845, -21846, 21845);

        // hold the result side so the pipe fills and the input stalls
        s_tvalid <= 1'b0;
        rx_hold_req = 1'b1;
        while (!rx_holding)
            @(posedge clk);
        repeat (24) send_item(random_orientation());
        wait_drained();

        for (int n = 0; n < 1250; n++)
        begin
            if ($urandom_range(0, 4) == 0)
                tx_idle($urandom_range(1, 14));
            else if (n == 600)
                wait_drained();
            send_item(random_orientation());
        end

        // closing stretch at full rate on both sides
        rx_stall_on = 1'b0;
        repeat (150) send_item(random_orientation());
        wait_drained();
        repeat (8) @(posedge clk);

        if (sb.errors == 0 && sb.count() == 0)
            $display("tb_image_mirror_rotate_from_orientation_top OK");
        else
            $display("tb_image_mirror_rotate_from_orientation_top NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/imr_pkg.sv
rtl/imr_front.sv
rtl/imr_axes.sv
rtl/imr_decide.sv
rtl/image_mirror_rotate_from_orientation_top.sv
tb/tb_image_mirror_rotate_from_orientation_top.sv
